// ===== src/tked_pkg.sv =====
// shared types, key codes, byte constants and decode tables for the escape decoder
`default_nettype none

package tked_pkg;

  typedef logic [4:0] key_t;
  typedef logic [7:0] byte_t;
  typedef logic [15:0] tick_t;
  typedef logic [1:0] cfg_idx_t;

  // decoder mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_ESC  = 4'b0010,
    MODE_CSI  = 4'b0100,
    MODE_SS3  = 4'b1000
  } mode_t;

  // register indexes
  localparam cfg_idx_t REG_ESC_WAIT = 2'd0;
  localparam cfg_idx_t REG_CSI_WAIT = 2'd1;
  localparam cfg_idx_t REG_SS3_WAIT = 2'd2;

  localparam tick_t ESC_WAIT_RST = 16'd100;
  localparam tick_t CSI_WAIT_RST = 16'd20;
  localparam tick_t SS3_WAIT_RST = 16'd10;
  localparam tick_t TICK_MAX     = 16'hFFFF;

  // item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // key codes
  localparam key_t K_CHAR      = 5'd0;
  localparam key_t K_TAB       = 5'd1;
  localparam key_t K_ENTER     = 5'd2;
  localparam key_t K_BACKSPACE = 5'd3;
  localparam key_t K_ESC       = 5'd4;
  localparam key_t K_UP        = 5'd5;
  localparam key_t K_DOWN      = 5'd6;
  localparam key_t K_RIGHT     = 5'd7;
  localparam key_t K_LEFT      = 5'd8;
  localparam key_t K_HOME      = 5'd9;
  localparam key_t K_END       = 5'd10;
  localparam key_t K_BACKTAB   = 5'd11;
  localparam key_t K_INSERT    = 5'd12;
  localparam key_t K_DELETE    = 5'd13;
  localparam key_t K_PGUP      = 5'd14;
  localparam key_t K_PGDN      = 5'd15;
  localparam key_t K_F1        = 5'd16;
  localparam key_t K_F2        = 5'd17;
  localparam key_t K_F3        = 5'd18;
  localparam key_t K_F4        = 5'd19;
  localparam key_t K_F5        = 5'd20;
  localparam key_t K_F6        = 5'd21;
  localparam key_t K_F7        = 5'd22;
  localparam key_t K_F8        = 5'd23;
  localparam key_t K_F9        = 5'd24;
  localparam key_t K_F10       = 5'd25;
  localparam key_t K_F11       = 5'd26;
  localparam key_t K_F12       = 5'd27;

  // byte values
  localparam byte_t CH_ESC   = 8'h1B;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_DEL   = 8'h7F;
  localparam byte_t CH_LBRK  = 8'h5B;
  localparam byte_t CH_O     = 8'h4F;
  localparam byte_t CH_TILDE = 8'h7E;
  localparam byte_t CH_SEMI  = 8'h3B;
  localparam byte_t CH_0     = 8'h30;
  localparam byte_t CH_9     = 8'h39;
  localparam byte_t CH_UA    = 8'h41;
  localparam byte_t CH_UZ    = 8'h5A;
  localparam byte_t CH_LA    = 8'h61;
  localparam byte_t CH_LZ    = 8'h7A;
  localparam byte_t CH_P     = 8'h50;
  localparam byte_t CH_S     = 8'h53;

  // key for a tilde final with a leading number
  function automatic key_t tilde_key(input byte_t n);
    key_t k;
    unique case (n)
      8'd1, 8'd7: k = K_HOME;
      8'd2:       k = K_INSERT;
      8'd3:       k = K_DELETE;
      8'd4, 8'd8: k = K_END;
      8'd5:       k = K_PGUP;
      8'd6:       k = K_PGDN;
      8'd11:      k = K_F1;
      8'd12:      k = K_F2;
      8'd13:      k = K_F3;
      8'd14:      k = K_F4;
      8'd15:      k = K_F5;
      8'd17:      k = K_F6;
      8'd18:      k = K_F7;
      8'd19:      k = K_F8;
      8'd20:      k = K_F9;
      8'd21:      k = K_F10;
      8'd23:      k = K_F11;
      8'd24:      k = K_F12;
      default:    k = K_ESC;
    endcase
    return k;
  endfunction

  // key for a final with no parameters
  function automatic key_t bare_final_key(input byte_t c);
    key_t k;
    unique case (c)
      8'h41:   k = K_UP;
      8'h42:   k = K_DOWN;
      8'h43:   k = K_RIGHT;
      8'h44:   k = K_LEFT;
      8'h48:   k = K_HOME;
      8'h46:   k = K_END;
      8'h5A:   k = K_BACKTAB;
      default: k = K_ESC;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== src/tked_if.sv =====
// channel interfaces: input bytes and ticks, key events, register writes
`default_nettype none

interface tked_in_if import tked_pkg::*;;
  logic  valid;
  logic  ready;
  logic  func;
  byte_t rx_byte;
  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface tked_out_if import tked_pkg::*;;
  logic  valid;
  logic  ready;
  key_t  key_code;
  byte_t char_value;
  modport source (output valid, output key_code, output char_value, input ready);
  modport sink   (input valid, input key_code, input char_value, output ready);
endinterface

interface tked_cfg_if import tked_pkg::*;;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  tick_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/terminal_key_escape_decoder_top.sv =====
// terminal key escape decoder: bytes and ticks in, key events out
//
//   channel  dir  payload                 transaction when
//   in_ch    in   func, rx_byte           valid && ready
//   out_ch   out  key_code, char_value    valid && ready
//   cfg_ch   in   index, data             valid && ready (ready always high)
//
// one item per cycle: the decode is a single pass from the input port
// into the result register, with the mode and counter state beside it.
// in_ch.ready drops only while a result waits in the output register and
// out_ch.ready is low; items that raise no result pass the same way.
// synchronous active-low reset puts the decoder idle, registers to defaults.
`default_nettype none

module terminal_key_escape_decoder_top import tked_pkg::*; #(
  parameter int MAX_PARAM_CHARS = 15
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tked_in_if.sink    in_ch,
  tked_out_if.source out_ch,
  tked_cfg_if.sink   cfg_ch
);

  localparam int PW = $clog2(MAX_PARAM_CHARS + 1);
  localparam logic [PW-1:0] PMAX = PW'(MAX_PARAM_CHARS);

  tick_t esc_wait_r, csi_wait_r, ss3_wait_r;

  mode_t         mode_r, mode_nxt;
  logic [PW-1:0] pcnt_r, pcnt_nxt;
  byte_t         num_r, num_nxt;
  logic          closed_r, closed_nxt;
  tick_t         wait_r, wait_nxt;

  logic  out_vld_r;
  key_t  key_r;
  byte_t ch_r;

  logic  in_acc;
  logic  emit;
  key_t  res_key;
  byte_t res_ch;
  tick_t wait_inc, limit;
  logic [PW-1:0] pcnt_inc;
  logic [11:0]   num_mul;
  byte_t c;

  assign c        = in_ch.rx_byte;
  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_vld_r;
  assign out_ch.key_code   = key_r;
  assign out_ch.char_value = ch_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_wait_r <= ESC_WAIT_RST;
      csi_wait_r <= CSI_WAIT_RST;
      ss3_wait_r <= SS3_WAIT_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_ESC_WAIT) esc_wait_r <= cfg_ch.data;
      if (cfg_ch.index == REG_CSI_WAIT) csi_wait_r <= cfg_ch.data;
      if (cfg_ch.index == REG_SS3_WAIT) ss3_wait_r <= cfg_ch.data;
    end
  end

  // decode of one item
  always_comb begin
    mode_nxt   = mode_r;
    pcnt_nxt   = pcnt_r;
    num_nxt    = num_r;
    closed_nxt = closed_r;
    wait_nxt   = wait_r;
    emit       = 1'b0;
    res_key    = K_ESC;
    res_ch     = '0;
    wait_inc   = (wait_r == TICK_MAX) ? wait_r : wait_r + 16'd1;
    pcnt_inc   = pcnt_r + PW'(1);
    num_mul    = 12'(num_r) * 12'd10 + 12'(c[3:0]);
    limit      = ss3_wait_r;
    if (mode_r == MODE_ESC) limit = esc_wait_r;
    else if (mode_r == MODE_CSI) limit = csi_wait_r;

    if (in_ch.func == FUNC_TICK) begin
      if (mode_r != MODE_IDLE) begin
        wait_nxt = wait_inc;
        if (wait_inc >= limit) emit = 1'b1;
      end
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (c == CH_ESC) begin
            mode_nxt = MODE_ESC;
            wait_nxt = '0;
          end else begin
            emit = 1'b1;
            if (c == CH_TAB) res_key = K_TAB;
            else if (c == CH_CR || c == CH_LF) res_key = K_ENTER;
            else if (c == CH_DEL) res_key = K_BACKSPACE;
            else begin
              res_key = K_CHAR;
              res_ch  = c;
            end
          end
        end
        MODE_ESC: begin
          if (c == CH_LBRK) begin
            mode_nxt   = MODE_CSI;
            pcnt_nxt   = '0;
            num_nxt    = '0;
            closed_nxt = 1'b0;
            wait_nxt   = '0;
          end else if (c == CH_O) begin
            mode_nxt = MODE_SS3;
            wait_nxt = '0;
          end else begin
            emit = 1'b1;
          end
        end
        MODE_CSI: begin
          wait_nxt = '0;
          if ((c >= CH_0 && c <= CH_9) || c == CH_SEMI) begin
            if (c == CH_SEMI) closed_nxt = 1'b1;
            else if (!closed_r) num_nxt = (num_mul > 12'd255) ? 8'd255 : num_mul[7:0];
            pcnt_nxt = pcnt_inc;
            if (pcnt_inc >= PMAX) emit = 1'b1;
          end else if ((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
                       c == CH_TILDE) begin
            emit = 1'b1;
            if (pcnt_r == '0) res_key = bare_final_key(c);
            else if (c == CH_TILDE) res_key = tilde_key(num_r);
          end
        end
        MODE_SS3: begin
          emit = 1'b1;
          if (c >= CH_P && c <= CH_S) res_key = K_F1 + key_t'(c[1:0]);
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end

    // any event returns the decoder to idle
    if (emit) begin
      mode_nxt   = MODE_IDLE;
      pcnt_nxt   = '0;
      num_nxt    = '0;
      closed_nxt = 1'b0;
      wait_nxt   = '0;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pcnt_r   <= '0;
      num_r    <= '0;
      closed_r <= 1'b0;
      wait_r   <= '0;
    end else if (in_acc) begin
      mode_r   <= mode_nxt;
      pcnt_r   <= pcnt_nxt;
      num_r    <= num_nxt;
      closed_r <= closed_nxt;
      wait_r   <= wait_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_acc && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      key_r <= res_key;
      ch_r  <= res_ch;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the terminal key escape decoder: directed table, then random traffic
module tb_top import tked_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PARAM_CHAR_LIMIT = 15;
  localparam int QUIET_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int NUM_PHASES       = 5;
  localparam int DIR_ROWS         = 27;

  // index past the three registers, writes there are dropped
  localparam cfg_idx_t REG_UNUSED = 2'd3;

  typedef struct packed {
    key_t  code;
    byte_t value;
  } key_event_t;

  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_KEY} check_kind_t;

  typedef struct packed {
    logic        func;
    byte_t       rx;
    int          reps;
    check_kind_t chk;
    key_t        code;
    byte_t       value;
  } stim_row_t;

  typedef struct packed {
    tick_t esc_lim;
    tick_t csi_lim;
    tick_t ss3_lim;
    int    send_pct;
    int    stall_pct;
    int    items;
    bit    poke_unused;
    bit    full_timeout;
  } phase_cfg_t;

  // directed stimulus, typed expectations where they are obvious
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{FUNC_TICK, 8'h00,    1,  EXP_NONE,  K_CHAR,      8'h00},  // tick while idle
    '{FUNC_BYTE, 8'h00,    1,  EXP_KEY,   K_CHAR,      8'h00},
    '{FUNC_BYTE, 8'hFF,    1,  EXP_KEY,   K_CHAR,      8'hFF},
    '{FUNC_BYTE, CH_TAB,   1,  EXP_KEY,   K_TAB,       8'h00},
    '{FUNC_BYTE, CH_CR,    1,  EXP_KEY,   K_ENTER,     8'h00},
    '{FUNC_BYTE, CH_LF,    1,  EXP_KEY,   K_ENTER,     8'h00},
    '{FUNC_BYTE, CH_DEL,   1,  EXP_KEY,   K_BACKSPACE, 8'h00},
    // unknown byte after escape
    '{FUNC_BYTE, CH_ESC,   1,  EXP_NONE,  K_CHAR,      8'h00},
    '{FUNC_BYTE, 8'h78,    1,  EXP_KEY,   K_ESC,       8'h00},
    // bare final
    '{FUNC_BYTE, CH_ESC,   1,  EXP_NONE,  K_CHAR,      8'h00},
    '{FUNC_BYTE, CH_LBRK,  1,  EXP_NONE,  K_CHAR,      8'h00},
    '{FUNC_BYTE, CH_UA,    1,  EXP_KEY,   K_UP,        8'h00},
    // number with a stray byte inside, tilde final
    '{FUNC_BYTE, CH_ESC,   1,  EXP_NONE,  K_CHAR,      8'h00},
    '{FUNC_BYTE, CH_LBRK,  1,  EXP_NONE,  K_CHAR,      8'h00},
    '{FUNC_BYTE, 8'h32,    1,  EXP_MODEL, K_CHAR,      8'h00},
    '{FUNC_BYTE, 8'h20,    1,  EXP_MODEL, K_CHAR,      8'h00},
    '{FUNC_BYTE, 8'h34,    1,  EXP_MODEL, K_CHAR,      8'h00},
    '{FUNC_BYTE, CH_TILDE, 1,  EXP_MODEL, K_CHAR,      8'h00},
    // function key through the O prefix
    '{FUNC_BYTE, CH_ESC,   1,  EXP_NONE,  K_CHAR,      8'h00},
    '{FUNC_BYTE, CH_O,     1,  EXP_NONE,  K_CHAR,      8'h00},
    '{FUNC_BYTE, CH_S,     1,  EXP_KEY,   K_F4,        8'h00},
    // too many parameter characters
    '{FUNC_BYTE, CH_ESC,   1,  EXP_NONE,  K_CHAR,      8'h00},
    '{FUNC_BYTE, CH_LBRK,  1,  EXP_NONE,  K_CHAR,      8'h00},
    '{FUNC_BYTE, CH_9,     15, EXP_MODEL, K_CHAR,      8'h00},
    // wait after the O prefix runs out
    '{FUNC_BYTE, CH_ESC,   1,  EXP_NONE,  K_CHAR,      8'h00},
    '{FUNC_BYTE, CH_O,     1,  EXP_NONE,  K_CHAR,      8'h00},
    '{FUNC_TICK, 8'h00,    10, EXP_MODEL, K_CHAR,      8'h00}
  };

  localparam byte_t BARE_FINALS [7] = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h48, 8'h46, 8'h5A};

  logic clk;
  logic rst_n;

  tked_in_if  in_ch ();
  tked_out_if out_ch ();
  tked_cfg_if cfg_ch ();

  terminal_key_escape_decoder_top #(
    .MAX_PARAM_CHARS(PARAM_CHAR_LIMIT)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // predicted decoder state and registers
  mode_t       dec_mode    = MODE_IDLE;
  int unsigned param_chars = 0;
  byte_t       lead_number = 8'h00;
  bit          lead_closed = 1'b0;
  tick_t       wait_ticks  = '0;
  tick_t       esc_limit   = ESC_WAIT_RST;
  tick_t       csi_limit   = CSI_WAIT_RST;
  tick_t       ss3_limit   = SS3_WAIT_RST;

  key_event_t  pending_keys [$];

  bit          typed_on;
  bit          typed_has;
  key_event_t  typed_evt;

  int          send_pct;
  int          stall_pct;
  int unsigned items_sent;
  int unsigned keys_seen    = 0;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // next key event for one accepted transaction, advances the predicted state
  function automatic bit decode_key(input logic f, input byte_t c, output key_event_t evt);
    bit          fire;
    key_t        k;
    byte_t       ch;
    tick_t       lim;
    int unsigned acc;
    fire = 1'b0;
    k    = K_ESC;
    ch   = 8'h00;
    if (f == FUNC_TICK) begin
      if (dec_mode != MODE_IDLE) begin
        if (wait_ticks != TICK_MAX) wait_ticks++;
        case (dec_mode)
          MODE_ESC: lim = esc_limit;
          MODE_CSI: lim = csi_limit;
          default:  lim = ss3_limit;
        endcase
        fire = (wait_ticks >= lim);
      end
    end else begin
      case (dec_mode)
        MODE_IDLE: begin
          if (c == CH_ESC) begin
            dec_mode   = MODE_ESC;
            wait_ticks = '0;
          end else begin
            fire = 1'b1;
            if (c == CH_TAB) k = K_TAB;
            else if (c == CH_CR || c == CH_LF) k = K_ENTER;
            else if (c == CH_DEL) k = K_BACKSPACE;
            else begin
              k  = K_CHAR;
              ch = c;
            end
          end
        end
        MODE_ESC: begin
          if (c == CH_LBRK) begin
            dec_mode    = MODE_CSI;
            param_chars = 0;
            lead_number = 8'h00;
            lead_closed = 1'b0;
            wait_ticks  = '0;
          end else if (c == CH_O) begin
            dec_mode   = MODE_SS3;
            wait_ticks = '0;
          end else begin
            fire = 1'b1;
          end
        end
        MODE_CSI: begin
          wait_ticks = '0;
          if ((c >= CH_0 && c <= CH_9) || c == CH_SEMI) begin
            if (c == CH_SEMI) begin
              lead_closed = 1'b1;
            end else if (!lead_closed) begin
              acc = int'(lead_number) * 10 + int'(c) - int'(CH_0);
              lead_number = (acc > 255) ? 8'hFF : byte_t'(acc);
            end
            param_chars++;
            fire = (param_chars >= PARAM_CHAR_LIMIT);
          end else if ((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
                       c == CH_TILDE) begin
            fire = 1'b1;
            if (param_chars == 0) begin
              case (c)
                8'h41:   k = K_UP;
                8'h42:   k = K_DOWN;
                8'h43:   k = K_RIGHT;
                8'h44:   k = K_LEFT;
                8'h48:   k = K_HOME;
                8'h46:   k = K_END;
                8'h5A:   k = K_BACKTAB;
                default: k = K_ESC;
              endcase
            end else if (c == CH_TILDE) begin
              case (lead_number)
                8'd1, 8'd7: k = K_HOME;
                8'd2:       k = K_INSERT;
                8'd3:       k = K_DELETE;
                8'd4, 8'd8: k = K_END;
                8'd5:       k = K_PGUP;
                8'd6:       k = K_PGDN;
                8'd11:      k = K_F1;
                8'd12:      k = K_F2;
                8'd13:      k = K_F3;
                8'd14:      k = K_F4;
                8'd15:      k = K_F5;
                8'd17:      k = K_F6;
                8'd18:      k = K_F7;
                8'd19:      k = K_F8;
                8'd20:      k = K_F9;
                8'd21:      k = K_F10;
                8'd23:      k = K_F11;
                8'd24:      k = K_F12;
                default:    k = K_ESC;
              endcase
            end
          end
        end
        default: begin
          fire = 1'b1;
          if (c >= CH_P && c <= CH_S) k = key_t'(int'(K_F1) + int'(c) - int'(CH_P));
        end
      endcase
    end
    // any key event returns the decoder to idle
    if (fire) begin
      dec_mode    = MODE_IDLE;
      param_chars = 0;
      lead_number = 8'h00;
      lead_closed = 1'b0;
      wait_ticks  = '0;
    end
    evt.code  = k;
    evt.value = ch;
    return fire;
  endfunction

  // one input transaction, with random sender gaps ahead of it
  task automatic send_item(input logic f, input byte_t b);
    key_event_t evt;
    bit         fire;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= f;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    fire = decode_key(f, b, evt);
    if (typed_on) begin
      fire = typed_has;
      evt  = typed_evt;
    end
    if (fire) pending_keys.push_back(evt);
    items_sent++;
  endtask

  // tick with a random byte riding along, which the block ignores
  task automatic send_tick();
    send_item(FUNC_TICK, byte_t'($urandom_range(255)));
  endtask

  // short random wait between bytes of a sequence
  task automatic pause_ticks();
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) send_tick();
  endtask

  task automatic open_csi();
    send_item(FUNC_BYTE, CH_ESC);
    pause_ticks();
    send_item(FUNC_BYTE, CH_LBRK);
  endtask

  // decimal digits, most significant first
  task automatic send_number(input int unsigned n);
    byte_t digs [$];
    do begin
      digs.push_front(byte_t'(int'(CH_0) + n % 10));
      n = n / 10;
    end while (n != 0);
    foreach (digs[i]) begin
      send_item(FUNC_BYTE, digs[i]);
      pause_ticks();
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input tick_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_ESC_WAIT: esc_limit = val;
      REG_CSI_WAIT: csi_limit = val;
      REG_SS3_WAIT: ss3_limit = val;
      default: ;
    endcase
  endtask

  // wait for every predicted key, then let in-flight transactions finish
  task automatic settle();
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random mix, mostly well-formed sequences with random content
  task automatic run_traffic(input int target);
    int unsigned pick;
    int unsigned stop_at;
    tick_t       lim;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_item(FUNC_BYTE, byte_t'($urandom_range(255)));
      end else if (pick < 30) begin
        repeat ($urandom_range(1, 3)) send_tick();
      end else if (pick < 60) begin
        // numbered sequence with tilde final
        open_csi();
        case ($urandom_range(3))
          0: send_number($urandom_range(1, 24));
          1: send_number($urandom_range(0, 999));
          2: begin
            send_number($urandom_range(1, 24));
            send_item(FUNC_BYTE, CH_SEMI);
            send_number($urandom_range(0, 99));
          end
          default: begin
            send_item(FUNC_BYTE, CH_SEMI);
            send_number($urandom_range(0, 30));
          end
        endcase
        if ($urandom_range(9) == 0) send_item(FUNC_BYTE, byte_t'($urandom_range(255)));
        send_item(FUNC_BYTE, CH_TILDE);
      end else if (pick < 72) begin
        // final with no parameters
        open_csi();
        pause_ticks();
        case ($urandom_range(9))
          0:       send_item(FUNC_BYTE, byte_t'(int'(CH_LA) + $urandom_range(25)));
          1:       send_item(FUNC_BYTE, byte_t'(int'(CH_UA) + $urandom_range(25)));
          2:       send_item(FUNC_BYTE, CH_TILDE);
          default: send_item(FUNC_BYTE, BARE_FINALS[$urandom_range(6)]);
        endcase
      end else if (pick < 80) begin
        // parameters closed by a letter
        open_csi();
        send_number($urandom_range(0, 30));
        if ($urandom_range(1) == 0) send_item(FUNC_BYTE, byte_t'(int'(CH_UA) + $urandom_range(25)));
        else send_item(FUNC_BYTE, byte_t'(int'(CH_LA) + $urandom_range(25)));
      end else if (pick < 88) begin
        send_item(FUNC_BYTE, CH_ESC);
        pause_ticks();
        send_item(FUNC_BYTE, CH_O);
        pause_ticks();
        if ($urandom_range(3) != 0) send_item(FUNC_BYTE, byte_t'(int'(CH_P) + $urandom_range(3)));
        else send_item(FUNC_BYTE, byte_t'($urandom_range(255)));
      end else if (pick < 92) begin
        send_item(FUNC_BYTE, CH_ESC);
        send_item(FUNC_BYTE, byte_t'($urandom_range(255)));
      end else if (pick < 96) begin
        // let the wait run out in one of the three modes, when its limit is 64 or less
        send_item(FUNC_BYTE, CH_ESC);
        lim = esc_limit;
        case ($urandom_range(2))
          1: begin
            send_item(FUNC_BYTE, CH_LBRK);
            lim = csi_limit;
          end
          2: begin
            send_item(FUNC_BYTE, CH_O);
            lim = ss3_limit;
          end
          default: ;
        endcase
        if (lim <= 64) repeat (int'(lim) + $urandom_range(2)) send_tick();
        else repeat ($urandom_range(1, 8)) send_tick();
      end else begin
        // run up to the parameter limit, and sometimes past it
        open_csi();
        repeat ($urandom_range(12, 18)) begin
          if ($urandom_range(3) == 0) send_item(FUNC_BYTE, CH_SEMI);
          else send_item(FUNC_BYTE, byte_t'(int'(CH_0) + $urandom_range(9)));
        end
      end
    end
  endtask

  task automatic run_phase(input phase_cfg_t p);
    write_reg(REG_ESC_WAIT, p.esc_lim);
    write_reg(REG_CSI_WAIT, p.csi_lim);
    write_reg(REG_SS3_WAIT, p.ss3_lim);
    if (p.poke_unused) write_reg(REG_UNUSED, tick_t'($urandom_range(65535)));
    cfg_ch.valid <= 1'b0;
    send_pct  = p.send_pct;
    stall_pct = p.stall_pct;
    run_traffic(p.items);
    // a full wait after a lone escape
    if (p.full_timeout) begin
      send_item(FUNC_BYTE, CH_ESC);
      repeat (int'(esc_limit)) send_tick();
    end
    in_ch.valid <= 1'b0;
    settle();
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // compare each key event with the oldest prediction
  always @(posedge clk) begin : key_check
    key_event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      keys_seen++;
      if (pending_keys.size() == 0) begin
        $error("unexpected key event: key_code %0d char_value %0d",
               out_ch.key_code, out_ch.char_value);
        fail_count++;
      end else begin
        want = pending_keys.pop_front();
        if (out_ch.key_code !== want.code) begin
          $error("key_code: expected %0d, actual %0d", want.code, out_ch.key_code);
          fail_count++;
        end
        if (out_ch.char_value !== want.value) begin
          $error("char_value: expected %0d, actual %0d", want.value, out_ch.char_value);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    phase_cfg_t plan [NUM_PHASES];
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= FUNC_BYTE;
    in_ch.rx_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_ESC_WAIT;
    cfg_ch.data   <= '0;
    send_pct      = 0;
    stall_pct     = 0;
    items_sent    = 0;
    typed_on      = 1'b0;

    plan[0] = '{16'd3, 16'd6, 16'd2, 0, 0, 180, 1'b0, 1'b0};
    plan[1] = '{16'd1, 16'd1, 16'd1, 45, 0, 150, 1'b0, 1'b0};
    plan[2] = '{16'd64, TICK_MAX, TICK_MAX, 0, 45, 150, 1'b0, 1'b1};
    plan[3] = '{tick_t'($urandom_range(1, 30)), tick_t'($urandom_range(1, 30)),
                tick_t'($urandom_range(1, 30)), 36, 36, 200, 1'b0, 1'b0};
    plan[4] = '{16'd40, 16'd60, 16'd25, 0, 0, 120, 1'b1, 1'b0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table at the reset register values
    foreach (DIRECTED[r]) begin
      for (int n = 0; n < DIRECTED[r].reps; n++) begin
        typed_on        = (DIRECTED[r].chk != EXP_MODEL);
        typed_has       = (DIRECTED[r].chk == EXP_KEY);
        typed_evt.code  = DIRECTED[r].code;
        typed_evt.value = DIRECTED[r].value;
        send_item(DIRECTED[r].func, DIRECTED[r].rx);
      end
    end
    typed_on = 1'b0;
    in_ch.valid <= 1'b0;
    settle();

    foreach (plan[p]) run_phase(plan[p]);

    $display("run covered %0d input transactions and %0d key events", items_sent, keys_seen);
    $display("over %0d register settings, from one-tick waits to the longest wait",
             NUM_PHASES + 1);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== terminal_key_escape_decoder_top.f =====
src/tked_pkg.sv
src/tked_if.sv
src/terminal_key_escape_decoder_top.sv
tb/tb_top.sv
